// ----- rtl/cpu_bus_address_decoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the processor bus address decoder
// Concurrent checks that are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CPU_BUS_ADDRESS_DECODER_CORE_MACROS_SVH
`define CPU_BUS_ADDRESS_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define CBAD_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("cbad check failed");
// Checks that a condition is followed in the next cycle by a consequence.
`define CBAD_ASSERT_NEXT(name, clk, rst, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("cbad sequence check failed");
`else
`define CBAD_ASSERT(name, clk, rst, prop)
`define CBAD_ASSERT_NEXT(name, clk, rst, cond, conseq)
`endif

`endif

// ----- rtl/cbad_pkg.sv -----
// ----------------------------------------------------------------------------
// Bus decoder package
// Sizes, route codes, address map constants and the decode result type.
// ----------------------------------------------------------------------------
package cbad_pkg;

  localparam int RAM_ADDR_BITS = 11;

  typedef logic [2:0] route_t;
  localparam route_t ROUTE_CART  = 3'd0;
  localparam route_t ROUTE_RAM   = 3'd1;
  localparam route_t ROUTE_PIC   = 3'd2;
  localparam route_t ROUTE_AUDIO = 3'd3;
  localparam route_t ROUTE_DMA   = 3'd4;
  localparam route_t ROUTE_PAD   = 3'd5;
  localparam route_t ROUTE_NONE  = 3'd6;

  // Where the data byte of a result comes from.
  typedef logic [2:0] bsrc_t;
  localparam bsrc_t BSRC_ZERO  = 3'd0;
  localparam bsrc_t BSRC_WRITE = 3'd1;
  localparam bsrc_t BSRC_CART  = 3'd2;
  localparam bsrc_t BSRC_PAD   = 3'd3;
  localparam bsrc_t BSRC_RAM   = 3'd4;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [15:0] ADDR_RAM_TOP   = 16'h1FFF;
  localparam logic [15:0] ADDR_PIC_TOP   = 16'h3FFF;
  localparam logic [15:0] ADDR_APU_BASE  = 16'h4000;
  localparam logic [15:0] ADDR_APU_TOP   = 16'h4013;
  localparam logic [15:0] ADDR_DMA       = 16'h4014;
  localparam logic [15:0] ADDR_APU_STAT  = 16'h4015;
  localparam logic [15:0] ADDR_PAD_ONE   = 16'h4016;
  localparam logic [15:0] ADDR_PAD_TWO   = 16'h4017;

  typedef struct packed {
    route_t     route;
    logic [4:0] reg_index;
    bsrc_t      byte_src;
    logic       ram_write;
    logic       pad_strobe;
    logic       pad_read;
    logic       pad_sel;
  } dec_t;

endpackage

// ----- rtl/cbad_bus_if.sv -----
// ----------------------------------------------------------------------------
// Bus decoder channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbad_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [15:0] address;
  logic [7:0] write_byte;
  logic       cart_claims;
  logic [7:0] cart_read_byte;
  logic [7:0] pad_one_buttons;
  logic [7:0] pad_two_buttons;

  modport source (
    output valid, operation, address, write_byte, cart_claims, cart_read_byte,
           pad_one_buttons, pad_two_buttons,
    input  ready
  );
  modport sink (
    input  valid, operation, address, write_byte, cart_claims, cart_read_byte,
           pad_one_buttons, pad_two_buttons,
    output ready
  );
endinterface

interface cbad_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] route;
  logic [4:0] reg_index;
  logic [7:0] data;

  modport source (output valid, route, reg_index, data, input ready);
  modport sink (input valid, route, reg_index, data, output ready);
endinterface

// ----- rtl/cbad_ram.sv -----
// ----------------------------------------------------------------------------
// Single-port synchronous RAM
// One read or one write per cycle; read data registered, held when idle.
// ----------------------------------------------------------------------------
module cbad_ram #(
  parameter int ADDR_BITS = 11,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [DATA_BITS-1:0] wdata,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/cbad_decode.sv -----
// ----------------------------------------------------------------------------
// Bus address decode
// Maps one access onto its route, register index and side effects.
// ----------------------------------------------------------------------------
module cbad_decode (
  input  logic            operation,
  input  logic [15:0]     address,
  input  logic            cart_claims,
  output cbad_pkg::dec_t  dec
);

  always_comb begin
    dec            = '0;
    dec.route      = cbad_pkg::ROUTE_NONE;
    dec.reg_index  = 5'd0;
    dec.byte_src   = cbad_pkg::BSRC_ZERO;
    if (cart_claims) begin
      dec.route    = cbad_pkg::ROUTE_CART;
      dec.byte_src = (operation == cbad_pkg::OP_WRITE) ? cbad_pkg::BSRC_WRITE
                                                       : cbad_pkg::BSRC_CART;
    end else if (address <= cbad_pkg::ADDR_RAM_TOP) begin
      dec.route     = cbad_pkg::ROUTE_RAM;
      dec.ram_write = (operation == cbad_pkg::OP_WRITE);
      dec.byte_src  = (operation == cbad_pkg::OP_WRITE) ? cbad_pkg::BSRC_WRITE
                                                        : cbad_pkg::BSRC_RAM;
    end else if (address <= cbad_pkg::ADDR_PIC_TOP) begin
      // Eight picture registers, mirrored through the whole window.
      dec.route     = cbad_pkg::ROUTE_PIC;
      dec.reg_index = {2'b00, address[2:0]};
      dec.byte_src  = (operation == cbad_pkg::OP_WRITE) ? cbad_pkg::BSRC_WRITE
                                                        : cbad_pkg::BSRC_ZERO;
    end else if (operation == cbad_pkg::OP_WRITE) begin
      if (address == cbad_pkg::ADDR_DMA) begin
        dec.route    = cbad_pkg::ROUTE_DMA;
        dec.byte_src = cbad_pkg::BSRC_WRITE;
      end else if (address == cbad_pkg::ADDR_PAD_ONE) begin
        dec.route      = cbad_pkg::ROUTE_PAD;
        dec.byte_src   = cbad_pkg::BSRC_WRITE;
        dec.pad_strobe = 1'b1;
      end else if (address inside {[cbad_pkg::ADDR_APU_BASE:cbad_pkg::ADDR_APU_TOP],
                                   cbad_pkg::ADDR_APU_STAT, cbad_pkg::ADDR_PAD_TWO}) begin
        // All audio addresses lie below base + 32, so the offset is the low bits.
        dec.route     = cbad_pkg::ROUTE_AUDIO;
        dec.reg_index = address[4:0];
        dec.byte_src  = cbad_pkg::BSRC_WRITE;
      end
    end else begin
      if (address == cbad_pkg::ADDR_PAD_ONE || address == cbad_pkg::ADDR_PAD_TWO) begin
        dec.route    = cbad_pkg::ROUTE_PAD;
        dec.byte_src = cbad_pkg::BSRC_PAD;
        dec.pad_read = 1'b1;
        dec.pad_sel  = address[0];
      end else if (address == cbad_pkg::ADDR_APU_STAT) begin
        dec.route     = cbad_pkg::ROUTE_AUDIO;
        dec.reg_index = address[4:0];
      end
    end
  end

endmodule

// ----- rtl/cbad_pads.sv -----
// ----------------------------------------------------------------------------
// Pad shift latches
// Two button latches loaded by a strobe and shifted out one bit per read.
// ----------------------------------------------------------------------------
module cbad_pads (
  input  logic       clk,
  input  logic       rst,
  input  logic       strobe,
  input  logic       shift,
  input  logic       sel,
  input  logic [7:0] pad_one_buttons,
  input  logic [7:0] pad_two_buttons,
  output logic       serial_bit
);

  logic [7:0] latch_one;
  logic [7:0] latch_two;

  assign serial_bit = sel ? latch_two[7] : latch_one[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_one <= 8'h00;
      latch_two <= 8'h00;
    end else if (strobe) begin
      latch_one <= pad_one_buttons;
      latch_two <= pad_two_buttons;
    end else if (shift) begin
      // A one fills from the bottom, so reads past the eighth return one.
      if (sel) begin
        latch_two <= {latch_two[6:0], 1'b1};
      end else begin
        latch_one <= {latch_one[6:0], 1'b1};
      end
    end
  end

endmodule

// ----- rtl/cpu_bus_address_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Processor bus address decoder core
// An accepted request passes through stage one, then the output register.
// Throughput: one transaction per cycle while results are taken and no sweep
// runs, set by the single work RAM port. Reset clears the pad latches and pipeline,
// then sweeps all 2**RAM_ADDR_BITS (2048) work RAM entries to zero, holding off requests.
// ----------------------------------------------------------------------------
`include "cpu_bus_address_decoder_core_macros.svh"

module cpu_bus_address_decoder_core (
  input  logic         clk,
  input  logic         rst,
  cbad_req_if.sink     req,
  cbad_rsp_if.source   rsp
);

  localparam int AW = cbad_pkg::RAM_ADDR_BITS;

  // Decode of the request presented on the input channel. The decode is
  // purely combinational; all side effects happen at the accepting edge.
  cbad_pkg::dec_t dec;

  cbad_decode u_decode (
    .operation   (req.operation),
    .address     (req.address),
    .cart_claims (req.cart_claims),
    .dec         (dec)
  );

  // Clearing sweep. After reset the work RAM is written with zeros one entry
  // per cycle; no request is taken until the sweep reaches the last entry.
  logic          clearing;
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == {AW{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  // Pipeline control. Stage one holds an accepted request while its RAM read
  // completes; the output register holds a finished result until taken.
  logic s1_valid;
  logic s1_move;
  logic req_accept;

  assign s1_move    = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready  = !clearing && (!s1_valid || s1_move);
  assign req_accept = req.valid && req.ready;

  // Work RAM. A write is committed at the accepting edge and a read is
  // launched there too, so a read right after a write to the same entry
  // already sees the new byte and no forwarding path is needed.
  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign ram_en    = clearing || req_accept;
  assign ram_we    = clearing || dec.ram_write;
  assign ram_addr  = clearing ? clr_cnt : req.address[AW-1:0];
  assign ram_wdata = clearing ? 8'h00 : req.write_byte;

  cbad_ram #(
    .ADDR_BITS (AW),
    .DATA_BITS (8)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Pad latches: loaded by a strobe write, shifted by a pad read. The bit
  // returned by a read is taken before the shift, at the accepting edge.
  logic pad_bit;

  cbad_pads u_pads (
    .clk             (clk),
    .rst             (rst),
    .strobe          (req_accept && dec.pad_strobe),
    .shift           (req_accept && dec.pad_read),
    .sel             (dec.pad_sel),
    .pad_one_buttons (req.pad_one_buttons),
    .pad_two_buttons (req.pad_two_buttons),
    .serial_bit      (pad_bit)
  );

  // Stage one: every data source except the RAM is resolved into a byte here.
  cbad_pkg::route_t s1_route;
  logic [4:0]       s1_reg_index;
  logic             s1_from_ram;
  logic [7:0]       s1_byte;
  logic [7:0]       s1_byte_next;

  always_comb begin
    case (dec.byte_src)
      cbad_pkg::BSRC_WRITE: s1_byte_next = req.write_byte;
      cbad_pkg::BSRC_CART:  s1_byte_next = req.cart_read_byte;
      cbad_pkg::BSRC_PAD:   s1_byte_next = {7'd0, pad_bit};
      default:              s1_byte_next = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_route     <= dec.route;
      s1_reg_index <= dec.reg_index;
      s1_from_ram  <= (dec.byte_src == cbad_pkg::BSRC_RAM);
      s1_byte      <= s1_byte_next;
    end
  end

  // Output register. The RAM read data stays put while stage one waits,
  // since the RAM only reads again when stage one is free to move.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_move) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.route     <= s1_route;
      rsp.reg_index <= s1_reg_index;
      rsp.data      <= s1_from_ram ? ram_rdata : s1_byte;
    end
  end

  // No request may slip in while the RAM is being swept.
  `CBAD_ASSERT(a_no_accept_clearing, clk, rst, !(clearing && req_accept))
  // A stage one transaction that cannot move is still there next cycle.
  `CBAD_ASSERT_NEXT(a_s1_holds, clk, rst, s1_valid && !s1_move, s1_valid)
  // A RAM read request lands in stage one marked to take the RAM data.
  `CBAD_ASSERT_NEXT(a_ram_read_tracked, clk, rst,
                    req_accept && dec.byte_src == cbad_pkg::BSRC_RAM,
                    s1_valid && s1_from_ram)
  // The sweep ends with the counter wrapped and the pipeline empty.
  `CBAD_ASSERT(a_sweep_done, clk, rst,
               $fell(clearing) |-> (clr_cnt == '0 && !s1_valid && !rsp.valid))

endmodule
